/* sv/isrt_pkg.sv */
// Package with shared types for the insertion sorter.
package isrt_pkg;

  typedef logic signed [31:0] value_t;

  // Per-cycle command broadcast from the controller to every cell.
  typedef struct packed {
    logic insert;  // insert the broadcast value into the chain
    logic drain;   // shift the whole chain one place toward cell 0
  } cell_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } sort_state_t;

endpackage

/* sv/isrt_cell.sv */
// One cell of the insertion chain: holds a single sorted value and its valid bit.
module isrt_cell (
  input  logic                clk,
  input  logic                rst,
  input  isrt_pkg::cell_ctrl_t ctrl,
  input  isrt_pkg::value_t    new_value,
  input  logic                left_take,
  input  logic                left_valid,
  input  isrt_pkg::value_t    left_value,
  input  logic                right_valid,
  input  isrt_pkg::value_t    right_value,
  output logic                take,
  output logic                valid,
  output isrt_pkg::value_t    value
);
  import isrt_pkg::*;

  // An empty cell counts as holding plus infinity, so it lies at or after the
  // insertion point. Equal values stay put, which keeps the sort stable.
  assign take = !valid || (value > new_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.drain) begin
      valid <= right_valid;
    end else if (ctrl.insert) begin
      valid <= valid | left_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.drain) begin
      value <= right_value;
    end else if (ctrl.insert && take) begin
      value <= left_take ? left_value : new_value;
    end
  end

endmodule

/* sv/insertion_sorter_unit.sv */
// Top level of the insertion sorter: cell chain, drain control and output register.
//
// The input channel (in_valid / in_ready, value, last) takes one signed value
// per transfer. Each value is inserted into a chain of DEPTH cells in the
// cycle it is accepted: every cell compares its content with the broadcast
// value and either keeps it, takes the value, or takes its left neighbor's
// content, so one value per cycle is accepted while a set is being collected.
// Equal values keep their arrival order. Values arriving while the chain is
// full are dropped and the set is marked as overflowed.
// A transfer with last high ends the set. Its value is inserted as usual, then
// the chain drains toward cell 0, one result per cycle while the receiver
// keeps up, through a registered output channel (out_valid / out_ready,
// sorted_value, end_of_set, overflow). The last transfer switches the state
// register to draining; the output register then takes results from cell 0.
// The input is not ready while the chain drains. A stall on the output simply
// holds the drain; no result is lost or repeated. Once the final result (with
// end_of_set high) is loaded, the chain is empty and input is taken again at
// the next cycle, even while that result still waits for the receiver.
// Reset clears every valid bit, the overflow mark and the output valid; no
// clearing pass is needed.
module insertion_sorter_unit #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  isrt_pkg::value_t value,
  input  logic             last,
  output logic             out_valid,
  input  logic             out_ready,
  output isrt_pkg::value_t sorted_value,
  output logic             end_of_set,
  output logic             overflow
);
  import isrt_pkg::*;

  sort_state_t state, state_next;
  cell_ctrl_t  ctrl;
  logic        dropped, dropped_next;

  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_take;
  value_t           cell_value [DEPTH];

  logic accept;
  logic chain_full;
  logic load;
  logic final_load;

  // Chain of cells. Cell 0 sees a virtual left neighbor that is valid and
  // never takes; the last cell sees an empty right neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   l_take, l_valid, r_valid;
    value_t l_value, r_value;

    if (i == 0) begin : g_left_edge
      assign l_take  = 1'b0;
      assign l_valid = 1'b1;
      assign l_value = value;
    end else begin : g_left_link
      assign l_take  = cell_take[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_right_edge
      assign r_valid = 1'b0;
      assign r_value = cell_value[i];
    end else begin : g_right_link
      assign r_valid = cell_valid[i+1];
      assign r_value = cell_value[i+1];
    end

    isrt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_value   (value),
      .left_take   (l_take),
      .left_valid  (l_valid),
      .left_value  (l_value),
      .right_valid (r_valid),
      .right_value (r_value),
      .take        (cell_take[i]),
      .valid       (cell_valid[i]),
      .value       (cell_value[i])
    );
  end

  assign chain_full = cell_valid[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_FILL;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
    end
  end

  always_comb begin
    state_next   = state;
    dropped_next = dropped;
    in_ready     = 1'b0;
    accept       = 1'b0;
    load         = 1'b0;
    final_load   = 1'b0;
    ctrl         = '0;
    unique case (state)
      ST_FILL: begin
        in_ready    = 1'b1;
        accept      = in_valid;
        ctrl.insert = accept && !chain_full;
        if (accept && chain_full) begin
          dropped_next = 1'b1;
        end
        if (accept && last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Move the head of the chain into the output register when it is free.
        load       = !out_valid || out_ready;
        final_load = load && !cell_valid[1];
        ctrl.drain = load;
        if (final_load) begin
          state_next   = ST_FILL;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sorted_value <= cell_value[0];
      end_of_set   <= !cell_valid[1];
      overflow     <= dropped;
    end
  end

  // While draining, the head cell always holds a value to emit.
  a_drain_head_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> cell_valid[0])
    else $error("drain with empty head cell");

  // Occupied cells always form a contiguous run starting at cell 0.
  a_chain_contiguous: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("gap in the cell chain");

  // Loading the final result leaves an empty chain ready for a new set.
  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    final_load |=> (state == ST_FILL) && (cell_valid == '0) && !dropped)
    else $error("chain not empty after final result");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the insertion sorter unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import isrt_pkg::*;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 310;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = DEPTH + 8;
  localparam int MAX_REPORTS  = 10;

  localparam value_t VMIN = 32'sh8000_0000;
  localparam value_t VMAX = 32'sh7fff_ffff;

  // Holds the running model of the sorted store and the queue of results that
  // the block still owes. Sets are sorted stably: a new value goes behind every
  // stored value that is not greater than it.
  class sort_scoreboard;
    typedef struct {
      value_t v;
      logic   eos;
      logic   ovf;
    } sorted_item_t;

    int           capacity;
    value_t       held[$];
    bit           dropped;
    sorted_item_t owed[$];
    int           mismatches;

    function new(int capacity_i);
      capacity = capacity_i;
    endfunction

    function void note_input(value_t v, logic is_last);
      int pos;
      if (held.size() >= capacity) begin
        dropped = 1'b1;
      end else begin
        pos = held.size();
        while (pos > 0 && held[pos-1] > v) pos--;
        held.insert(pos, v);
      end
      if (is_last) begin
        foreach (held[k]) owed.insert(owed.size(), '{held[k], (k == held.size() - 1), dropped});
        held.delete();
        dropped = 1'b0;
      end
    endfunction

    function void check_result(value_t v, logic eos, logic ovf);
      sorted_item_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: sorted_value %0d end_of_set %b overflow %b",
                   v, eos, ovf);
      end else begin
        want = owed.pop_front();
        if (want.v !== v || want.eos !== eos || want.ovf !== ovf) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp value %0d eos %b ovf %b, got value %0d eos %b ovf %b",
                     want.v, want.eos, want.ovf, v, eos, ovf);
        end
      end
    endfunction

    function int owed_count();
      return owed.size();
    endfunction
  endclass

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   in_ready;
  value_t value     = '0;
  logic   last      = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  value_t sorted_value;
  logic   end_of_set;
  logic   overflow;

  // Idle and stall odds in percent, changed per test phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // A long receiver hold-off is requested by bumping hold_req; the receiver
  // counts out the hold itself and then catches hold_done up.
  int hold_req   = 0;
  int hold_done  = 0;
  int hold_count = 0;

  int quiet_cycles = 0;

  sort_scoreboard ledger = new(DEPTH);

  insertion_sorter_unit #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .end_of_set   (end_of_set),
    .overflow     (overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver either sits out a requested hold-off or stalls at random.
  always @(posedge clk) begin
    if (hold_req != hold_done) begin
      out_ready <= 1'b0;
      if (hold_count == HOLD_CYCLES) begin
        hold_count <= 0;
        hold_done  <= hold_done + 1;
      end else begin
        hold_count <= hold_count + 1;
      end
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Both channels are sampled at the rising edge, where the values seen are
  // the ones that were stable during the cycle before. An input transfer is
  // noted before any output transfer of the same edge; the first result of a
  // set can only come at a later edge than its last input, so ordering stays FIFO.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) ledger.note_input(value, last);
      if (out_valid && out_ready) ledger.check_result(sorted_value, end_of_set, overflow);
    end
  end

  // The watchdog ends a run that has stopped moving in both directions.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one value, with random idle cycles ahead of it, and returns right
  // after the edge at which the transfer took place. Valid stays high between
  // back-to-back transfers.
  task automatic offer_value(input value_t v, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= is_last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic offer_set(input value_t vals[$]);
    foreach (vals[k]) offer_value(vals[k], k == vals.size() - 1);
  endtask

  // Mixes full-range values with a narrow band that makes duplicates common,
  // a wider band around zero, and the extremes of the signed range, zero and -1.
  function automatic value_t pick_value();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3, 4: return value_t'($urandom);
      5, 6:          return value_t'($urandom_range(15)) - 8;
      7: begin
        case ($urandom_range(3))
          0:       return VMIN;
          1:       return VMAX;
          2:       return '0;
          default: return -1;
        endcase
      end
      default:       return value_t'($urandom_range(2000)) - 1000;
    endcase
  endfunction

  task automatic offer_random_set(input int n);
    for (int k = 0; k < n; k++) offer_value(pick_value(), k == n - 1);
  endtask

  task automatic enter_phase(input int phase);
    case (phase)
      0: begin
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
      end
      1: begin
        send_idle_pct  <= 56;
        recv_stall_pct <= 0;
      end
      2: begin
        send_idle_pct  <= 0;
        recv_stall_pct <= 56;
      end
      default: begin
        send_idle_pct  <= 27;
        recv_stall_pct <= 27;
      end
    endcase
  endtask

  initial begin
    value_t picks[$];
    int     sent;
    int     set_no;
    int     len;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed sets: a lone minimum and a lone maximum, the extremes mixed
    // with zero and its neighbors, and fully descending and ascending runs.
    picks = '{VMIN};
    offer_set(picks);
    picks = '{VMAX};
    offer_set(picks);
    picks = '{VMAX, VMIN, 0, -1, 1, VMAX, VMIN, 5, 5};
    offer_set(picks);
    picks = '{3, 2, 1, 0, -1, -2};
    offer_set(picks);
    picks = '{-5, -4, -3, 4, VMAX};
    offer_set(picks);

    // Random sets, spread over the four idling phases. The no-idling phase
    // opens with a long receiver hold-off: the first set drains into the
    // stalled output and the next one backs up at the input. Two sets fill
    // the store exactly and one past it, so that the closing value of the
    // latter is itself dropped.
    sent   = 0;
    set_no = 0;
    hold_req <= hold_req + 1;
    while (sent < RANDOM_ITEMS) begin
      enter_phase(sent * 4 / RANDOM_ITEMS);
      if (set_no == 4)
        len = DEPTH;
      else if (set_no == 9)
        len = DEPTH + 1;
      else if ($urandom_range(19) == 0)
        len = $urandom_range(DEPTH + 6, DEPTH - 4);
      else
        len = $urandom_range(12, 1);
      offer_random_set(len);
      sent   += len;
      set_no += 1;
    end
    in_valid <= 1'b0;
    recv_stall_pct <= 0;

    while (ledger.owed_count() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (ledger.mismatches == 0 && ledger.owed_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
